[sv/assert_macros.svh]
// Assertion helpers for the framed line receiver.
// Included by xfr_datapath, the module that carries concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define XFR_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("xfr: check failed");

// Antecedent in one cycle implies consequent in the next.
`define XFR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("xfr: sequence check failed");

`endif

[sv/xfr_pkg.sv]
// Shared types, character codes and helpers for the framed line receiver.
// No dependencies.
`timescale 1ns / 1ps

package xfr_pkg;

  typedef enum logic [1:0] {
    KIND_STOP  = 2'd0,
    KIND_BYTE  = 2'd1,
    KIND_EMPTY = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SEND
  } state_e;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_X_LO   = 8'h78;
  localparam logic [7:0] CH_X_UP   = 8'h58;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;

  // Controller -> datapath
  typedef struct packed {
    logic  take_byte;
    logic  load_single;
    kind_e single_kind;
    logic  start_emit;
    logic  rd_en;
    logic  load_byte;
  } ctl_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic byte_stop;
    logic frame_bytes;
    logic frame_empty;
    logic out_free;
    logic emit_last;
  } dp_status_t;

  // {valid, nibble}
  function automatic logic [4:0] hex_value(input logic [7:0] h);
    logic [4:0] r;
    r = 5'd0;
    if (h >= 8'h30 && h <= 8'h39) begin
      r = {1'b1, 4'(h - 8'h30)};
    end else if (h >= 8'h41 && h <= 8'h46) begin
      r = {1'b1, 4'(h - 8'h37)};
    end else if (h >= 8'h61 && h <= 8'h66) begin
      r = {1'b1, 4'(h - 8'h57)};
    end
    return r;
  endfunction

endpackage

[sv/xfr_datapath.sv]
// Frame store, running checksum, emission counter and output register.
// Depends on xfr_pkg and assert_macros.svh; driven by xfr_ctrl commands.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module xfr_datapath #(
  parameter int BUF_DEPTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [7:0]            rx_byte_i,
  input  xfr_pkg::ctl_cmd_t     cmd_i,
  output xfr_pkg::dp_status_t   status_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [1:0]            kind_o,
  output logic [7:0]            data_o,
  output logic                  last_o
);

  localparam int AW = $clog2(BUF_DEPTH);
  localparam logic [AW-1:0] LEN_MAX = AW'(BUF_DEPTH - 1);

  logic [7:0]    mem [BUF_DEPTH];

  logic          in_frame_q, in_frame_d;
  logic [AW-1:0] len_q, len_d;
  logic [7:0]    sum_q, sum_d;
  logic [7:0]    b1_q, b2_q, b3_q;
  logic [AW-1:0] n_q;
  logic [AW-1:0] idx_q, idx_d;
  logic [7:0]    rd_data_q;
  logic          out_valid_q, out_valid_d;
  xfr_pkg::kind_e out_kind_q;
  logic [7:0]    out_data_q;
  logic          out_last_q;

  logic          is_stop, is_start, is_term, do_store;
  logic [4:0]    hex_hi, hex_lo;
  logic          frame_ok;
  logic [AW-1:0] payload_n;

  assign is_stop  = (rx_byte_i == xfr_pkg::CH_X_LO) || (rx_byte_i == xfr_pkg::CH_X_UP);
  assign is_start = (rx_byte_i == xfr_pkg::CH_DOLLAR);
  assign is_term  = in_frame_q && !is_stop && !is_start &&
                    ((rx_byte_i == xfr_pkg::CH_LF) || (rx_byte_i == xfr_pkg::CH_CR));
  assign do_store = in_frame_q && !is_stop && !is_start && !is_term && (len_q < LEN_MAX);

  // b3/b2/b1 are the last three stored bytes: '*', high digit, low digit.
  assign hex_hi    = xfr_pkg::hex_value(b2_q);
  assign hex_lo    = xfr_pkg::hex_value(b1_q);
  assign payload_n = len_q - AW'(3);
  assign frame_ok  = (len_q >= AW'(3)) && (b3_q == xfr_pkg::CH_STAR) &&
                     hex_hi[4] && hex_lo[4] &&
                     ((sum_q ^ b1_q ^ b2_q ^ b3_q) == {hex_hi[3:0], hex_lo[3:0]});

  assign status_o.byte_stop   = is_stop;
  assign status_o.frame_bytes = is_term && frame_ok && (payload_n != '0);
  assign status_o.frame_empty = is_term && frame_ok && (payload_n == '0);
  assign status_o.out_free    = !out_valid_q || out_ready_i;
  assign status_o.emit_last   = (idx_q == n_q - AW'(1));

  always_comb begin
    in_frame_d = in_frame_q;
    len_d      = len_q;
    sum_d      = sum_q;
    if (cmd_i.take_byte) begin
      if (is_stop) begin
        in_frame_d = 1'b0;
        len_d      = '0;
      end else if (is_start) begin
        in_frame_d = 1'b1;
        len_d      = '0;
        sum_d      = 8'h00;
      end else if (in_frame_q) begin
        if (do_store) begin
          len_d = len_q + AW'(1);
          sum_d = sum_q ^ rx_byte_i;
        end else begin
          // terminator or overlong frame
          in_frame_d = 1'b0;
          len_d      = '0;
        end
      end
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.start_emit) begin
      idx_d = '0;
    end else if (cmd_i.load_byte) begin
      idx_d = idx_q + AW'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.load_single || cmd_i.load_byte) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q  <= 1'b0;
      len_q       <= '0;
      sum_q       <= 8'h00;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      in_frame_q  <= in_frame_d;
      len_q       <= len_d;
      sum_q       <= sum_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_byte && do_store) begin
      mem[len_q] <= rx_byte_i;
      b1_q       <= rx_byte_i;
      b2_q       <= b1_q;
      b3_q       <= b2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_data_q <= mem[idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_emit) begin
      n_q <= payload_n;
    end
    if (cmd_i.load_single) begin
      out_kind_q <= cmd_i.single_kind;
      out_data_q <= 8'h00;
      out_last_q <= 1'b1;
    end else if (cmd_i.load_byte) begin
      out_kind_q <= xfr_pkg::KIND_BYTE;
      out_data_q <= rd_data_q;
      out_last_q <= status_o.emit_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = out_kind_q;
  assign data_o      = out_data_q;
  assign last_o      = out_last_q;

  `XFR_ASSERT(a_idle_len_zero, clk_i, rst_ni, in_frame_q || (len_q == '0))
  `XFR_ASSERT(a_no_overwrite, clk_i, rst_ni,
              !(cmd_i.load_single || cmd_i.load_byte) || status_o.out_free)
  `XFR_ASSERT_NEXT(a_emit_count, clk_i, rst_ni, cmd_i.start_emit,
                   (idx_q == '0) && (n_q != '0))

endmodule

[sv/xfr_ctrl.sv]
// Sequencer for the framed line receiver: byte intake and payload emission.
// Depends on xfr_pkg; drives xfr_datapath through ctl_cmd_t.
`timescale 1ns / 1ps

module xfr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  xfr_pkg::dp_status_t status_i,
  output xfr_pkg::ctl_cmd_t   cmd_o
);

  xfr_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= xfr_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d           = state_q;
    in_ready_o        = 1'b0;
    cmd_o.take_byte   = 1'b0;
    cmd_o.load_single = 1'b0;
    cmd_o.single_kind = xfr_pkg::KIND_STOP;
    cmd_o.start_emit  = 1'b0;
    cmd_o.rd_en       = 1'b0;
    cmd_o.load_byte   = 1'b0;
    case (state_q)
      xfr_pkg::S_IDLE: begin
        // one-result requests go straight into the output register
        in_ready_o = status_i.out_free;
        if (in_valid_i && status_i.out_free) begin
          cmd_o.take_byte = 1'b1;
          if (status_i.byte_stop) begin
            cmd_o.load_single = 1'b1;
            cmd_o.single_kind = xfr_pkg::KIND_STOP;
          end else if (status_i.frame_empty) begin
            cmd_o.load_single = 1'b1;
            cmd_o.single_kind = xfr_pkg::KIND_EMPTY;
          end else if (status_i.frame_bytes) begin
            cmd_o.start_emit = 1'b1;
            state_d          = xfr_pkg::S_READ;
          end
        end
      end
      xfr_pkg::S_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = xfr_pkg::S_SEND;
      end
      xfr_pkg::S_SEND: begin
        if (status_i.out_free) begin
          cmd_o.load_byte = 1'b1;
          state_d = status_i.emit_last ? xfr_pkg::S_IDLE : xfr_pkg::S_READ;
        end
      end
      default: begin
        state_d = xfr_pkg::S_IDLE;
      end
    endcase
  end

endmodule

[sv/xor_framed_line_receiver.sv]
// Top level of the XOR-checked framed line receiver.
// Depends on xfr_pkg, xfr_ctrl and xfr_datapath.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o/rx_byte_i) takes one received byte
//   per request. Output channel (out_valid_o/out_ready_i) carries results:
//   kind_o (stop, payload byte, empty command), data_o and last_o.
//   A frame is '$' payload '*' HH then LF or CR; 'x'/'X' always yields a stop.
//   A plain byte is taken without leaving S_IDLE. A stop or empty command is
//   placed in the output register in the cycle the byte is accepted and
//   appears the next. A valid frame with n payload bytes emits them one by
//   one: a frame-store read (S_READ), then an output load (S_SEND, held while
//   the output register is full); no input byte is taken until the last is loaded.
//   Frames are at most BUF_DEPTH-1 stored bytes; longer ones are discarded.
//   A result waiting in the output register does not block intake as long as
//   out_ready_i takes it; a stalled receiver holds results and in_ready_o low.
//   Reset clears frame tracking and the output valid; stored bytes are not
//   cleared and are only read after being written in the current frame.
`timescale 1ns / 1ps

module xor_framed_line_receiver #(
  parameter int BUF_DEPTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] kind_o,
  output logic [7:0] data_o,
  output logic       last_o
);

  xfr_pkg::ctl_cmd_t   cmd;
  xfr_pkg::dp_status_t status;

  xfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  xfr_datapath #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_byte_i   (rx_byte_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_o      (kind_o),
    .data_o      (data_o),
    .last_o      (last_o)
  );

endmodule

[tb/sv/tb.sv]
// Testbench for xor_framed_line_receiver: random and directed byte streams,
// with the expected results predicted in-bench and checked in order.
// Depends on xfr_pkg and the receiver RTL.
`timescale 1ns / 1ps

module tb;

  localparam int BUF_DEPTH   = 32;
  localparam int NUM_ITEMS   = 360;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 80;

  typedef struct packed {
    xfr_pkg::kind_e kind;
    logic [7:0]     data;
    logic           last;
  } line_result_t;

  typedef struct {
    logic [7:0] value;
    bit         hold;
  } rx_request_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [7:0] rx_byte_i   = 8'h00;
  logic       out_ready_i = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [1:0] kind_o;
  logic [7:0] data_o;
  logic       last_o;

  rx_request_t  pending_bytes[$];
  line_result_t exp_results[$];

  // receiver state as tracked by the bench
  logic       frame_open;
  int         held_count;
  logic [7:0] held_bytes[BUF_DEPTH];

  int accepted_items = 0;
  int total_items    = 0;
  int result_count   = 0;
  int mismatch_count = 0;
  int cycle_count    = 0;

  xor_framed_line_receiver #(
    .BUF_DEPTH(BUF_DEPTH)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .rx_byte_i  (rx_byte_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .kind_o     (kind_o),
    .data_o     (data_o),
    .last_o     (last_o)
  );

  always #4 clk_i = ~clk_i;

  // {valid, value} of a checksum digit
  function automatic logic [4:0] digit_value(input logic [7:0] c);
    logic [7:0] folded;
    folded = c | 8'h20;  // folds upper-case letters onto lower case
    if (c >= 8'h30 && c <= 8'h39) return {1'b1, c[3:0]};
    if (folded >= 8'h61 && folded <= 8'h66) return {1'b1, 4'(folded - 8'h57)};
    return 5'd0;
  endfunction

  function automatic void decode_byte(input logic [7:0] c);
    logic [4:0] hi;
    logic [4:0] lo;
    logic [7:0] sum;
    int         n;
    if (c == xfr_pkg::CH_X_LO || c == xfr_pkg::CH_X_UP) begin
      frame_open = 1'b0;
      held_count = 0;
      exp_results.push_back('{kind: xfr_pkg::KIND_STOP, data: 8'h00, last: 1'b1});
    end else if (c == xfr_pkg::CH_DOLLAR) begin
      frame_open = 1'b1;
      held_count = 0;
    end else if (frame_open) begin
      if (c == xfr_pkg::CH_LF || c == xfr_pkg::CH_CR) begin
        n = held_count;
        frame_open = 1'b0;
        held_count = 0;
        if (n >= 3 && held_bytes[n-3] == xfr_pkg::CH_STAR) begin
          hi = digit_value(held_bytes[n-2]);
          lo = digit_value(held_bytes[n-1]);
          sum = 8'h00;
          for (int i = 0; i < n - 3; i++) sum ^= held_bytes[i];
          if (hi[4] && lo[4] && sum == {hi[3:0], lo[3:0]}) begin
            if (n == 3) begin
              exp_results.push_back('{kind: xfr_pkg::KIND_EMPTY, data: 8'h00,
                                      last: 1'b1});
            end
            for (int i = 0; i < n - 3; i++) begin
              exp_results.push_back('{kind: xfr_pkg::KIND_BYTE, data: held_bytes[i],
                                      last: (i == n - 4)});
            end
          end
        end
      end else if (held_count < BUF_DEPTH - 1) begin
        held_bytes[held_count] = c;
        held_count++;
      end else begin
        // overlong: whole frame and this byte are dropped
        frame_open = 1'b0;
        held_count = 0;
      end
    end
  endfunction

  // ---- stimulus construction ----
  function automatic void queue_byte(input logic [7:0] c);
    pending_bytes.push_back('{value: c, hold: 1'b0});
  endfunction

  function automatic void queue_text(input string s);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
  endfunction

  function automatic bit is_special(input logic [7:0] c);
    return c == xfr_pkg::CH_X_LO || c == xfr_pkg::CH_X_UP || c == xfr_pkg::CH_DOLLAR ||
           c == xfr_pkg::CH_LF || c == xfr_pkg::CH_CR;
  endfunction

  function automatic logic [7:0] payload_byte();
    logic [7:0] c;
    if ($urandom_range(7) == 0) return xfr_pkg::CH_STAR;
    do c = 8'($urandom); while (is_special(c));
    return c;
  endfunction

  function automatic logic [7:0] non_hex_byte();
    logic [7:0] c;
    logic [4:0] d;
    do begin
      c = 8'($urandom);
      d = digit_value(c);
    end while (is_special(c) || d[4]);
    return c;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit upper);
    if (nib < 4'd10) return 8'h30 + 8'(nib);
    return (upper ? 8'h41 : 8'h61) + 8'(nib) - 8'd10;
  endfunction

  function automatic logic [7:0] end_byte();
    return $urandom_range(1) ? xfr_pkg::CH_LF : xfr_pkg::CH_CR;
  endfunction

  function automatic void add_sequence();
    logic [7:0] sum;
    logic [7:0] ck;
    logic [7:0] c;
    logic [7:0] hi;
    logic [7:0] lo;
    int         sel;
    int         n;
    sel = $urandom_range(99);
    sum = 8'h00;
    if (sel < 10) begin
      repeat ($urandom_range(6, 1)) queue_byte(8'($urandom));
      return;
    end
    if (sel < 14) begin
      // too short to hold a checksum
      queue_byte(xfr_pkg::CH_DOLLAR);
      repeat ($urandom_range(2)) queue_byte(payload_byte());
      queue_byte(end_byte());
      return;
    end
    if (sel >= 82 && sel < 88) n = $urandom_range(34, 29);
    else if ($urandom_range(9) == 0) n = $urandom_range(28, 20);
    else n = $urandom_range(12);
    queue_byte(xfr_pkg::CH_DOLLAR);
    for (int i = 0; i < n; i++) begin
      c = payload_byte();
      sum ^= c;
      queue_byte(c);
    end
    if (sel >= 88 && sel < 94) begin
      // abort mid-frame: stop byte, or leave open for a restart by the next '$'
      if ($urandom_range(1)) begin
        queue_byte($urandom_range(1) ? xfr_pkg::CH_X_LO : xfr_pkg::CH_X_UP);
      end
      return;
    end
    ck = sum;
    if (sel >= 70 && sel < 76) ck = sum ^ (8'd1 << $urandom_range(7));
    if (sel < 94) queue_byte(xfr_pkg::CH_STAR);
    hi = hex_char(ck[7:4], 1'($urandom_range(1)));
    lo = hex_char(ck[3:0], 1'($urandom_range(1)));
    if (sel >= 76 && sel < 82) begin
      if ($urandom_range(1)) hi = non_hex_byte();
      else lo = non_hex_byte();
    end
    queue_byte(hi);
    queue_byte(lo);
    queue_byte(end_byte());
  endfunction

  // ---- idling profile ----
  function automatic int tx_idle_pct();
    if (accepted_items < total_items / 3) return 13;
    if (accepted_items < 2 * total_items / 3) return 78;
    return 0;
  endfunction

  function automatic int rx_idle_pct();
    if (accepted_items < total_items / 3) return 78;
    if (accepted_items < 2 * total_items / 3) return 13;
    return 0;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_count < 40) begin
      $display("MISMATCH result %0d: %s got %0h expected %0h", result_count, what, got, want);
    end
    mismatch_count++;
  endtask

  // ---- request driver ----
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        decode_byte(rx_byte_i);
        accepted_items++;
      end
      if (!in_valid_i || in_ready_o) begin
        // a hold request waits until every expected result has drained
        if (pending_bytes.size() != 0 &&
            !(pending_bytes[0].hold && exp_results.size() != 0) &&
            $urandom_range(99) >= tx_idle_pct()) begin
          rx_byte_i  <= pending_bytes[0].value;
          in_valid_i <= 1'b1;
          void'(pending_bytes.pop_front());
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---- result monitor ----
  always @(posedge clk_i) begin
    line_result_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (exp_results.size() == 0) begin
          report_mismatch("unexpected result, kind", int'(kind_o), 0);
        end else begin
          want = exp_results.pop_front();
          if (kind_o != want.kind) begin
            report_mismatch("kind", int'(kind_o), int'(want.kind));
          end
          if (data_o != want.data) begin
            report_mismatch("data", int'(data_o), int'(want.data));
          end
          if (last_o != want.last) begin
            report_mismatch("last", int'(last_o), int'(want.last));
          end
        end
        result_count++;
      end
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct());
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("xor_framed_line_receiver test failed");
      $finish;
    end
  end

  initial begin
    frame_open = 1'b0;
    held_count = 0;

    // directed: stops, empty command, extreme payload bytes, bad digit,
    // ignored byte outside a frame, restart inside a frame
    queue_byte(xfr_pkg::CH_X_LO);
    queue_byte(xfr_pkg::CH_X_UP);
    queue_text("$*00\r");
    queue_byte(xfr_pkg::CH_DOLLAR);
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_text("*ff\n");
    queue_text("$*0G\n");
    queue_text("Z");
    queue_text("$1$*00\n");

    while (pending_bytes.size() < NUM_ITEMS) add_sequence();
    total_items = pending_bytes.size();
    pending_bytes[total_items / 3].hold = 1'b1;
    pending_bytes[2 * total_items / 3].hold = 1'b1;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (accepted_items < total_items) @(posedge clk_i);
    while (exp_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (mismatch_count == 0 && exp_results.size() == 0) begin
      $display("xor_framed_line_receiver test passed");
    end else begin
      $display("xor_framed_line_receiver test failed");
    end
    $finish;
  end

endmodule
